// ===== rtl/nbh_pkg.sv =====
// ----------------------------------------------------------------------------
// nbh_pkg
// Shared constants, types and codes for the n-gram bucket hash block.
// ----------------------------------------------------------------------------
package nbh_pkg;

  localparam int MaxOrder     = 3;
  localparam int MaxHeads     = 8;
  localparam int MaxLayers    = 4;
  localparam int HistDepth    = MaxOrder - 1;
  localparam int ColsPerLayer = (MaxOrder - 1) * MaxHeads;
  localparam int MulDepth     = MaxLayers * MaxOrder;
  localparam int PriDepth     = MaxLayers * ColsPerLayer;
  localparam int MulAw        = (MulDepth > 1) ? $clog2(MulDepth) : 1;
  localparam int PriAw        = (PriDepth > 1) ? $clog2(PriDepth) : 1;
  localparam int OrdW         = $clog2(MaxOrder + 1);
  localparam int HeadW        = $clog2(MaxHeads + 1);
  localparam int LayW         = $clog2(MaxLayers + 1);

  localparam logic [1:0] FuncToken = 2'd0;
  localparam logic [1:0] FuncMul   = 2'd1;
  localparam logic [1:0] FuncPrime = 2'd2;

  localparam logic [1:0] RegPad   = 2'd0;
  localparam logic [1:0] RegOrder = 2'd1;
  localparam logic [1:0] RegHeads = 2'd2;
  localparam logic [1:0] RegLayer = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StMulRd,
    StMulAcc,
    StPriRd,
    StDivGo,
    StDiv,
    StOut
  } state_e;

  // request from the sequencer to the remainder unit
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [30:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] rem;
  } div_rsp_t;

endpackage

// ===== rtl/nbh_rem_unit.sv =====
// ----------------------------------------------------------------------------
// nbh_rem_unit
// Restoring bit-serial 64-bit by 31-bit remainder, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module nbh_rem_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  nbh_pkg::div_req_t req_i,
  output nbh_pkg::div_rsp_t rsp_o
);

  logic [63:0] num_q, num_d;
  logic [31:0] acc_q, acc_d;
  logic [30:0] dvs_q, dvs_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [31:0] trial;
  logic [32:0] diff;

  always_comb begin
    num_d  = num_q;
    acc_d  = acc_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {acc_q[30:0], num_q[63]};
    diff   = {1'b0, trial} - {2'b00, dvs_q};
    if (req_i.start) begin
      num_d  = req_i.dividend;
      acc_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = 7'd64;
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[62:0], 1'b0};
      acc_d = diff[32] ? trial : diff[31:0];
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    acc_q <= acc_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = {32'd0, acc_q};

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("remainder done held");
  a_rem_lt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && dvs_q != '0 |-> acc_q < {1'b0, dvs_q}) else $error("remainder too large");
  a_busy_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0) else $error("busy with zero count");

endmodule

// ===== rtl/ngram_bucket_hash_top.sv =====
// ----------------------------------------------------------------------------
// ngram_bucket_hash_top
// Multiplicative XOR n-gram hash producing bucket row ids per layer and head.
// ----------------------------------------------------------------------------
// A token transfer occupies the block until its last row id has entered the
// output register, including any wait while a finished row is held in the output
// register: each row id runs through a shared bit-serial remainder unit, and
// each window product is formed on one shared 32x32 multiplier in two halves.
// Table writes produce no output. in_ready_o is low while a token is being
// processed; results leave through a single output register.
module ngram_bucket_hash_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [30:0] token_id_i,
  input  logic        token_dead_i,
  input  logic        seq_start_i,
  input  logic [1:0]  layer_sel_i,
  input  logic [3:0]  entry_index_i,
  input  logic [62:0] table_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  layer_o,
  output logic [3:0]  column_o,
  output logic [30:0] row_id_o,
  output logic        gate_o,
  output logic        last_o
);

  // configuration
  logic [30:0] pad_q;
  logic [1:0]  order_q;
  logic [3:0]  heads_q;
  logic [2:0]  layers_q;
  logic        wr_en;
  logic [1:0]  wr_idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign wr_idx = paddr[3:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_q    <= '0;
      order_q  <= 2'd3;
      heads_q  <= 4'd8;
      layers_q <= 3'd1;
    end else if (wr_en) begin
      unique case (wr_idx)
        nbh_pkg::RegPad: pad_q <= pwdata[30:0];
        nbh_pkg::RegOrder: begin
          if (pwdata[1:0] < 2'd2) order_q <= 2'd2;
          else if (32'(pwdata[1:0]) > nbh_pkg::MaxOrder) order_q <= 2'(nbh_pkg::MaxOrder);
          else order_q <= pwdata[1:0];
        end
        nbh_pkg::RegHeads: begin
          if (pwdata[3:0] == 4'd0) heads_q <= 4'd1;
          else if (32'(pwdata[3:0]) > nbh_pkg::MaxHeads) heads_q <= 4'(nbh_pkg::MaxHeads);
          else heads_q <= pwdata[3:0];
        end
        default: begin
          if (pwdata[2:0] == 3'd0) layers_q <= 3'd1;
          else if (32'(pwdata[2:0]) > nbh_pkg::MaxLayers) layers_q <= 3'(nbh_pkg::MaxLayers);
          else layers_q <= pwdata[2:0];
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      nbh_pkg::RegPad:   prdata = {1'b0, pad_q};
      nbh_pkg::RegOrder: prdata = {30'd0, order_q};
      nbh_pkg::RegHeads: prdata = {28'd0, heads_q};
      default:           prdata = {29'd0, layers_q};
    endcase
  end

  // tables
  logic [62:0] mul_mem [nbh_pkg::MulDepth];
  logic [30:0] pri_mem [nbh_pkg::PriDepth];
  logic [62:0] mul_rd_q;
  logic [30:0] pri_rd_q;
  logic [nbh_pkg::MulAw-1:0] mul_ra;
  logic [nbh_pkg::PriAw-1:0] pri_ra;
  logic in_fire, mul_we, pri_we;

  assign in_fire = in_valid_i & in_ready_o;
  assign mul_we  = in_fire && func_i == nbh_pkg::FuncMul &&
                   32'(layer_sel_i) < nbh_pkg::MaxLayers &&
                   32'(entry_index_i) < nbh_pkg::MaxOrder;
  assign pri_we  = in_fire && func_i == nbh_pkg::FuncPrime &&
                   32'(layer_sel_i) < nbh_pkg::MaxLayers &&
                   32'(entry_index_i) < nbh_pkg::ColsPerLayer;

  always_ff @(posedge clk_i) begin
    if (mul_we)
      mul_mem[nbh_pkg::MulAw'(32'(layer_sel_i) * nbh_pkg::MaxOrder + 32'(entry_index_i))]
        <= table_value_i;
    if (pri_we)
      pri_mem[nbh_pkg::PriAw'(32'(layer_sel_i) * nbh_pkg::ColsPerLayer + 32'(entry_index_i))]
        <= table_value_i[30:0];
    mul_rd_q <= mul_mem[mul_ra];
    pri_rd_q <= pri_mem[pri_ra];
  end

  // sequencer state
  nbh_pkg::state_e st_q, st_d;
  logic [30:0] hist_id_q [nbh_pkg::HistDepth];
  logic        hist_dead_q [nbh_pkg::HistDepth];
  logic [30:0] tok_q;
  logic        dead_q;
  logic [2:0]  lay_q, lay_d;
  logic [1:0]  j_q, j_d;
  logic [3:0]  h_q, h_d;
  logic [3:0]  c_q, c_d;
  logic        half_q, half_d;
  logic [63:0] hv_q, hv_d;
  logic [63:0] base_q, base_d;
  logic [63:0] prod_q, prod_d;
  logic        ov_q, ov_d;
  logic [30:0] ov_row_q, ov_row_d;
  logic [3:0]  ov_col_q, ov_col_d;
  logic [1:0]  ov_lay_q, ov_lay_d;
  logic        ov_last_q, ov_last_d;
  logic [30:0] win_j;
  logic        blk;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        last_row;
  nbh_pkg::div_req_t dreq;
  nbh_pkg::div_rsp_t drsp;

  nbh_rem_unit u_rem (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // window slot j with sticky blocking
  always_comb begin
    blk   = dead_q;
    win_j = dead_q ? pad_q : tok_q;
    for (int k = 1; k < nbh_pkg::MaxOrder; k++) begin
      blk = blk | hist_dead_q[k-1];
      if (32'(j_q) == k) win_j = blk ? pad_q : hist_id_q[k-1];
    end
  end

  // 31 x 63 product mod 2^64 in two halves on one multiplier
  assign mul_a = {1'b0, win_j};
  assign mul_b = half_q ? {1'b0, mul_rd_q[62:32]} : mul_rd_q[31:0];
  assign mul_p = mul_a * mul_b;

  assign mul_ra = nbh_pkg::MulAw'(32'(lay_q) * nbh_pkg::MaxOrder + 32'(j_q));
  assign pri_ra = nbh_pkg::PriAw'(32'(lay_q) * nbh_pkg::ColsPerLayer + 32'(c_q));
  assign last_row = (lay_q == layers_q - 3'd1) && (j_q == order_q - 2'd1) &&
                    (h_q == heads_q - 4'd1);

  always_comb begin
    st_d      = st_q;
    lay_d     = lay_q;
    j_d       = j_q;
    h_d       = h_q;
    c_d       = c_q;
    half_d    = half_q;
    hv_d      = hv_q;
    base_d    = base_q;
    prod_d    = prod_q;
    ov_d      = ov_q & ~out_ready_i;
    ov_row_d  = ov_row_q;
    ov_col_d  = ov_col_q;
    ov_lay_d  = ov_lay_q;
    ov_last_d = ov_last_q;
    dreq.start    = 1'b0;
    dreq.dividend = hv_q;
    dreq.divisor  = pri_rd_q;
    in_ready_o    = (st_q == nbh_pkg::StIdle);
    unique case (st_q)
      nbh_pkg::StIdle: begin
        if (in_fire && func_i == nbh_pkg::FuncToken) begin
          st_d = nbh_pkg::StMulRd;
          lay_d = '0; j_d = '0; h_d = '0; c_d = '0; half_d = 1'b0;
          hv_d = '0; base_d = '0;
        end
      end
      nbh_pkg::StMulRd: st_d = nbh_pkg::StMulAcc;
      nbh_pkg::StMulAcc: begin
        if (!half_q) begin
          prod_d = mul_p;
          half_d = 1'b1;
        end else begin
          half_d = 1'b0;
          hv_d   = hv_q ^ (prod_q + {mul_p[31:0], 32'd0});
          if (j_q == '0) begin
            j_d  = 2'd1;
            st_d = nbh_pkg::StMulRd;
          end else begin
            st_d = nbh_pkg::StPriRd;
          end
        end
      end
      // prime address settles here; the registered read is valid next cycle
      nbh_pkg::StPriRd: st_d = nbh_pkg::StDivGo;
      nbh_pkg::StDivGo: begin
        dreq.start = 1'b1;
        st_d = nbh_pkg::StDiv;
      end
      nbh_pkg::StDiv: begin
        if (drsp.done) st_d = nbh_pkg::StOut;
      end
      default: begin
        if (!ov_q || out_ready_i) begin
          ov_d      = 1'b1;
          ov_row_d  = 31'((pri_rd_q == '0 ? hv_q : drsp.rem) + base_q);
          ov_col_d  = c_q;
          ov_lay_d  = lay_q[1:0];
          ov_last_d = last_row;
          base_d    = base_q + {33'd0, pri_rd_q};
          c_d       = c_q + 4'd1;
          if (h_q != heads_q - 4'd1) begin
            h_d  = h_q + 4'd1;
            st_d = nbh_pkg::StPriRd;
          end else begin
            h_d = '0;
            if (j_q != order_q - 2'd1) begin
              j_d  = j_q + 2'd1;
              st_d = nbh_pkg::StMulRd;
            end else if (lay_q != layers_q - 3'd1) begin
              lay_d = lay_q + 3'd1;
              j_d = '0; c_d = '0; hv_d = '0; base_d = '0;
              st_d = nbh_pkg::StMulRd;
            end else begin
              st_d = nbh_pkg::StIdle;
            end
          end
        end
      end
    endcase
  end

  // rem register holds until the next start, so it is valid in StOut
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= nbh_pkg::StIdle;
      ov_q   <= 1'b0;
      for (int k = 0; k < nbh_pkg::HistDepth; k++) begin
        hist_id_q[k]   <= '0;
        hist_dead_q[k] <= 1'b1;
      end
    end else begin
      st_q <= st_d;
      ov_q <= ov_d;
      if (in_fire && func_i == nbh_pkg::FuncToken && seq_start_i)
        for (int k = 0; k < nbh_pkg::HistDepth; k++) hist_dead_q[k] <= 1'b1;
      // shift history once the token is finished
      if (st_q != nbh_pkg::StIdle && st_d == nbh_pkg::StIdle) begin
        for (int k = nbh_pkg::HistDepth - 1; k > 0; k--) begin
          hist_id_q[k]   <= hist_id_q[k-1];
          hist_dead_q[k] <= hist_dead_q[k-1];
        end
        hist_id_q[0]   <= tok_q;
        hist_dead_q[0] <= dead_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && func_i == nbh_pkg::FuncToken) begin
      tok_q  <= token_id_i;
      dead_q <= token_dead_i;
    end
    lay_q     <= lay_d;
    j_q       <= j_d;
    h_q       <= h_d;
    c_q       <= c_d;
    half_q    <= half_d;
    hv_q      <= hv_d;
    base_q    <= base_d;
    prod_q    <= prod_d;
    ov_row_q  <= ov_row_d;
    ov_col_q  <= ov_col_d;
    ov_lay_q  <= ov_lay_d;
    ov_last_q <= ov_last_d;
  end

  logic gate_q;
  always_ff @(posedge clk_i) begin
    if (st_q == nbh_pkg::StOut && (!ov_q || out_ready_i)) gate_q <= ~dead_q;
  end

  assign out_valid_o = ov_q;
  assign layer_o     = ov_lay_q;
  assign column_o    = ov_col_q;
  assign row_id_o    = ov_row_q;
  assign gate_o      = gate_q;
  assign last_o      = ov_last_q;

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q != nbh_pkg::StIdle |-> !in_ready_o) else $error("ready while busy");
  a_div_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drsp.done |-> st_q == nbh_pkg::StDiv) else $error("remainder done out of step");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == nbh_pkg::StOut && st_d == nbh_pkg::StIdle |-> last_row)
    else $error("finished without last row");

endmodule
